/* src/ntis_pkg.sv */
package ntis_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = 10;
    localparam int CNT_W       = 11;
    localparam int TIME_W      = 32;
    localparam int BOUND_W     = CNT_W + 1;
    localparam int DIST_W      = TIME_W + 1;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // request codes
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // classified command: a table write carries index and time, a query its time
    typedef struct packed {
        logic                     is_query;
        logic [IDX_W-1:0]         index;
        logic signed [TIME_W-1:0] value;
    } t_cmd;

endpackage

/* src/ntis_front.sv */
module ntis_front
    import ntis_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic                     i_req_type,
    input  logic [IDX_W-1:0]         i_entry_index,
    input  logic signed [TIME_W-1:0] i_entry_time,
    input  logic signed [TIME_W-1:0] i_query_time,
    output t_cmd                     o_cmd,
    output logic                     o_cmd_valid,
    input  logic                     i_cmd_take
);

    t_cmd              r_queue [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    t_cmd              push_cmd;
    logic              push;
    logic              pop;

    // classify the incoming transaction
    always_comb begin
        push_cmd.is_query = (i_req_type == REQ_QUERY);
        push_cmd.index    = i_entry_index;
        push_cmd.value    = (i_req_type == REQ_QUERY) ? i_query_time : i_entry_time;
    end

    assign o_busy      = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign push        = i_start && !o_busy;
    assign o_cmd_valid = (r_count != '0);
    assign pop         = o_cmd_valid && i_cmd_take;
    assign o_cmd       = r_queue[r_rd_ptr];

    // queue pointers and fill level
    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= push_cmd;
        end
    end

endmodule

/* src/ntis_back.sv */
module ntis_back
    import ntis_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    input  t_cmd             i_cmd,
    input  logic             i_cmd_valid,
    output logic             o_cmd_take,
    output logic             o_found_valid,
    output logic [IDX_W-1:0] o_found_index
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_PROBE = 3'd2;
    localparam logic [2:0] ST_NEAR1 = 3'd3;
    localparam logic [2:0] ST_NEAR2 = 3'd4;
    localparam logic [2:0] ST_NEAR3 = 3'd5;

    logic signed [TIME_W-1:0]  r_mem [TABLE_DEPTH];
    logic signed [TIME_W-1:0]  r_rd_data;
    logic [IDX_W-1:0]          mem_addr;
    logic                      mem_we;

    logic [CNT_W-1:0]          r_entry_count;
    logic [2:0]                r_state, n_state;
    logic signed [BOUND_W-1:0] r_low, n_low;
    logic signed [BOUND_W-1:0] r_high, n_high;
    logic [IDX_W-1:0]          r_mid, n_mid;
    logic signed [TIME_W-1:0]  r_query, n_query;
    logic [IDX_W-1:0]          r_best, n_best;
    logic [DIST_W-1:0]         r_best_d, n_best_d;
    logic                      r_found_valid, n_found_valid;
    logic [IDX_W-1:0]          r_found_index, n_found_index;

    logic [CNT_W-1:0]          eff_count;
    logic signed [BOUND_W-1:0] eff_n;
    logic [BOUND_W:0]          mid_sum;
    logic [IDX_W-1:0]          mid;
    logic signed [BOUND_W-1:0] mid_ext;
    logic signed [DIST_W-1:0]  diff;
    logic [DIST_W-1:0]         rd_dist;
    logic                      has_next;
    logic [IDX_W-1:0]          high_idx;

    // count saturated to the table depth
    assign eff_count = (r_entry_count > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                               : r_entry_count;
    assign eff_n     = $signed({1'b0, eff_count});

    // midpoint of a non-negative interval
    assign mid_sum = {1'b0, r_low} + {1'b0, r_high};
    assign mid     = mid_sum[IDX_W:1];
    assign mid_ext = $signed({{(BOUND_W-IDX_W){1'b0}}, r_mid});

    // exact distance from the query to the word just read
    assign diff     = $signed({r_query[TIME_W-1], r_query})
                    - $signed({r_rd_data[TIME_W-1], r_rd_data});
    assign rd_dist  = diff[DIST_W-1] ? DIST_W'(-diff) : DIST_W'(diff);
    assign has_next = (r_high + BOUND_W'(1)) < eff_n;
    assign high_idx = r_high[IDX_W-1:0];

    // search sequencer
    always_comb begin
        n_state       = r_state;
        n_low         = r_low;
        n_high        = r_high;
        n_mid         = r_mid;
        n_query       = r_query;
        n_best        = r_best;
        n_best_d      = r_best_d;
        n_found_valid = 1'b0;
        n_found_index = r_found_index;
        mem_addr      = '0;
        mem_we        = 1'b0;
        o_cmd_take    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_cmd_take = 1'b1;
                mem_addr   = i_cmd.index;
                if (i_cmd_valid) begin
                    if (i_cmd.is_query) begin
                        n_query = i_cmd.value;
                        n_low   = '0;
                        n_high  = eff_n - BOUND_W'(1);
                        n_state = ST_CHECK;
                    end else begin
                        mem_we = 1'b1;
                    end
                end
            end
            ST_CHECK: begin
                if (r_high <= 0) begin
                    n_found_valid = 1'b1;
                    n_found_index = '0;
                    n_state       = ST_IDLE;
                end else if (r_low >= r_high) begin
                    mem_addr = high_idx - 1'b1;
                    n_state  = ST_NEAR1;
                end else begin
                    mem_addr = mid;
                    n_mid    = mid;
                    n_state  = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (r_query == r_rd_data) begin
                    n_found_valid = 1'b1;
                    n_found_index = r_mid;
                    n_state       = ST_IDLE;
                end else if (r_query < r_rd_data) begin
                    n_high  = mid_ext - BOUND_W'(1);
                    n_state = ST_CHECK;
                end else begin
                    n_low   = mid_ext + BOUND_W'(1);
                    n_state = ST_CHECK;
                end
            end
            ST_NEAR1: begin
                // entry below high
                mem_addr = high_idx;
                n_best   = high_idx - 1'b1;
                n_best_d = rd_dist;
                n_state  = ST_NEAR2;
            end
            ST_NEAR2: begin
                // entry at high, ties go to the later index
                mem_addr = high_idx + 1'b1;
                if (!(r_best_d < rd_dist)) begin
                    n_best   = high_idx;
                    n_best_d = rd_dist;
                end
                if (has_next) begin
                    n_state = ST_NEAR3;
                end else begin
                    n_found_valid = 1'b1;
                    n_found_index = (r_best_d < rd_dist) ? r_best : high_idx;
                    n_state       = ST_IDLE;
                end
            end
            ST_NEAR3: begin
                // entry above high
                n_found_valid = 1'b1;
                n_found_index = (r_best_d < rd_dist) ? r_best : high_idx + 1'b1;
                n_state       = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_found_valid <= 1'b0;
            r_entry_count <= '0;
        end else begin
            r_state       <= n_state;
            r_found_valid <= n_found_valid;
            if (i_cfg_we) begin
                r_entry_count <= i_cfg_wdata;
            end
        end
    end

    // search datapath
    always_ff @(posedge i_clk) begin
        r_low         <= n_low;
        r_high        <= n_high;
        r_mid         <= n_mid;
        r_query       <= n_query;
        r_best        <= n_best;
        r_best_d      <= n_best_d;
        r_found_index <= n_found_index;
    end

    // time stamp table, one port, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= i_cmd.value;
        end
        r_rd_data <= r_mem[mem_addr];
    end

    assign o_found_valid = r_found_valid;
    assign o_found_index = r_found_index;

endmodule

/* src/nearest_time_index_search.sv */
// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+---------------------------------------------
// request   | in        | start / busy       | i_req_type, i_entry_index, i_entry_time,
//           |           |                    | i_query_time
// result    | out       | o_found_valid      | o_found_index
// config    | in        | i_cfg_we           | i_cfg_wdata (entry_count)
//
// the search engine does a write transaction in its idle state once it leaves the queue
// a query alternates check and probe states until the interval closes, then reads the
// entries below, at and above high; a probe needs both states for the registered table read
// a two-entry queue takes new transactions while a query runs; busy means the queue is full
// reset is synchronous and active low; the table is not cleared, entry_count goes to 0
// each result is shown for one cycle and the receiver cannot stall
module nearest_time_index_search
    import ntis_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_req_type,
    input  logic [IDX_W-1:0]         i_entry_index,
    input  logic signed [TIME_W-1:0] i_entry_time,
    input  logic signed [TIME_W-1:0] i_query_time,
    input  logic                     i_cfg_we,
    input  logic [CNT_W-1:0]         i_cfg_wdata,
    output logic                     o_found_valid,
    output logic [IDX_W-1:0]         o_found_index
);

    t_cmd cmd;
    logic cmd_valid;
    logic cmd_take;

    // accept and queue
    ntis_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .o_busy        (busy),
        .i_req_type    (i_req_type),
        .i_entry_index (i_entry_index),
        .i_entry_time  (i_entry_time),
        .i_query_time  (i_query_time),
        .o_cmd         (cmd),
        .o_cmd_valid   (cmd_valid),
        .i_cmd_take    (cmd_take)
    );

    // table and search engine
    ntis_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_cmd         (cmd),
        .i_cmd_valid   (cmd_valid),
        .o_cmd_take    (cmd_take),
        .o_found_valid (o_found_valid),
        .o_found_index (o_found_index)
    );

endmodule

/* src/ntis_checker.sv */
module ntis_checker
    import ntis_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             busy,
    input logic             i_cfg_we,
    input logic [CNT_W-1:0] i_cfg_wdata,
    input logic             o_found_valid,
    input logic [IDX_W-1:0] o_found_index
);

    logic [CNT_W-1:0] r_count;

    // shadow of the entry count as written on the port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_wdata;
        end
    end

    // results are never back to back
    a_no_adjacent_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_found_valid |=> !o_found_valid)
        else $error("two results in adjacent cycles");

    // small table answers index zero
    a_small_table_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_found_valid && (r_count <= CNT_W'(1))) |-> (o_found_index == '0))
        else $error("small table gave a nonzero index");

    // answer lies inside the loaded part of the table
    a_index_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_found_valid && (r_count > CNT_W'(1)) && (r_count <= CNT_W'(TABLE_DEPTH)))
        |-> ({1'b0, o_found_index} < r_count))
        else $error("index beyond entry count");

    // quiet and ready right after reset
    a_idle_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (!busy && !o_found_valid))
        else $error("not idle after reset");

endmodule

bind nearest_time_index_search ntis_checker u_ntis_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .busy          (busy),
    .i_cfg_we      (i_cfg_we),
    .i_cfg_wdata   (i_cfg_wdata),
    .o_found_valid (o_found_valid),
    .o_found_index (o_found_index)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import ntis_pkg::*;

    localparam int          CYCLE_LIMIT   = 500000;
    localparam int          SETTLE_CYCLES = 64;
    localparam int          QUERY_TARGET  = 400;
    localparam int          QUIET_FROM    = 330;
    localparam logic signed [TIME_W-1:0] TIME_MIN = 32'sh8000_0000;
    localparam logic signed [TIME_W-1:0] TIME_MAX = 32'sh7fff_ffff;

    // tracks the time table and entry_count, predicts found_index per query
    class nearest_tracker;
        logic signed [TIME_W-1:0] stamps [TABLE_DEPTH];
        bit                       loaded [TABLE_DEPTH];
        logic [CNT_W-1:0]         stamp_count;
        logic [IDX_W-1:0]         pending_index [$];
        int                       errors;
        int                       queries;
        int                       writes;

        function new();
            stamp_count = '0;
            errors      = 0;
            queries     = 0;
            writes      = 0;
        endfunction

        function bit filled(int m);
            for (int i = 0; i < m; i++) begin
                if (!loaded[i]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function longint spread(logic signed [TIME_W-1:0] q, int i);
            longint d;
            d = longint'(q) - longint'(stamps[i]);
            return (d < 0) ? -d : d;
        endfunction

        // true when a search for q reads only entries that were written
        function bit walk_loaded(logic signed [TIME_W-1:0] q);
            int n;
            int lo;
            int hi;
            int mid;
            n  = (stamp_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(stamp_count);
            lo = 0;
            hi = n - 1;
            while (hi > 0) begin
                if (lo >= hi)
                    return loaded[hi - 1] && loaded[hi] && ((hi + 1 >= n) || loaded[hi + 1]);
                mid = (lo + hi) / 2;
                if (!loaded[mid]) return 1'b0;
                if (q == stamps[mid]) return 1'b1;
                if (q < stamps[mid]) hi = mid - 1;
                else lo = mid + 1;
            end
            return 1'b1;
        endfunction

        // binary search, then nearest of high-1, high, high+1 with ties to the later
        function logic [IDX_W-1:0] nearest_index(logic signed [TIME_W-1:0] q);
            int     n;
            int     lo;
            int     hi;
            int     mid;
            int     later;
            bit     has_next;
            longint d1;
            longint d2;
            longint d3;
            n  = (stamp_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(stamp_count);
            lo = 0;
            hi = n - 1;
            while (hi > 0) begin
                if (lo >= hi) begin
                    has_next = (hi + 1) < n;
                    d1       = spread(q, hi - 1);
                    d2       = spread(q, hi);
                    d3       = has_next ? spread(q, hi + 1) : d2;
                    later    = has_next ? hi + 1 : hi;
                    if (d1 < d2) return IDX_W'((d1 < d3) ? hi - 1 : later);
                    return IDX_W'((d2 < d3) ? hi : later);
                end
                mid = (lo + hi) / 2;
                if (q == stamps[mid]) return IDX_W'(mid);
                if (q < stamps[mid]) hi = mid - 1;
                else lo = mid + 1;
            end
            return '0;
        endfunction

        // accepted request transaction
        function void take_request(logic req, logic [IDX_W-1:0] idx,
                                   logic signed [TIME_W-1:0] et,
                                   logic signed [TIME_W-1:0] qt);
            if (req == REQ_WRITE) begin
                stamps[idx] = et;
                loaded[idx] = 1'b1;
                writes++;
            end else begin
                pending_index.push_back(nearest_index(qt));
                queries++;
            end
        endfunction

        // result transaction against the oldest outstanding query
        function void take_found(logic [IDX_W-1:0] got);
            logic [IDX_W-1:0] want;
            if (pending_index.size() == 0) begin
                $error("found_index %0d arrived with no query outstanding", got);
                errors++;
            end else begin
                want = pending_index.pop_front();
                if (got !== want) begin
                    $error("found_index mismatch: expected %0d, actual %0d", want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     start         = 1'b0;
    logic                     busy;
    logic                     i_req_type    = REQ_WRITE;
    logic [IDX_W-1:0]         i_entry_index = '0;
    logic signed [TIME_W-1:0] i_entry_time  = '0;
    logic signed [TIME_W-1:0] i_query_time  = '0;
    logic                     i_cfg_we      = 1'b0;
    logic [CNT_W-1:0]         i_cfg_wdata   = '0;
    logic                     o_found_valid;
    logic [IDX_W-1:0]         o_found_index;

    nearest_tracker           sb;
    bit                       pausing       = 1'b0;
    bit                       spine_ready   = 1'b0;
    int                       configs       = 0;
    int unsigned              cycle_count   = 0;
    logic signed [TIME_W-1:0] corner_times [11] = '{
        32'sd0, TIME_MIN, TIME_MAX, 32'sh0001_0000, -32'sd32768, 32'sd1, -32'sd1,
        32'sh8000_0001, 32'sh7fff_fffe, 32'sh7000_0000, -32'sd65536
    };

    nearest_time_index_search dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req_type    (i_req_type),
        .i_entry_index (i_entry_index),
        .i_entry_time  (i_entry_time),
        .i_query_time  (i_query_time),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_found_valid (o_found_valid),
        .o_found_index (o_found_index)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result monitor, the receiver never stalls
    always @(posedge i_clk) begin
        if (i_rst_n && o_found_valid) sb.take_found(o_found_index);
    end

    function automatic logic signed [TIME_W-1:0] to_time(longint v);
        if (v < longint'(TIME_MIN)) return TIME_MIN;
        if (v > longint'(TIME_MAX)) return TIME_MAX;
        return TIME_W'(v);
    endfunction

    // query time mostly near the loaded stamps: hits, near misses, midpoints, extremes, else random
    function automatic logic signed [TIME_W-1:0] pick_query(int m);
        int     i;
        longint a;
        longint b;
        longint v;
        if (m == 0) return $urandom;
        i = $urandom_range(m - 1, 0);
        a = sb.stamps[i];
        b = (i + 1 < m) ? longint'(sb.stamps[i + 1]) : a;
        case ($urandom_range(5, 0))
            0: v = a;
            1: v = (a + b) / 2;
            2: v = a + longint'($urandom_range(3, 1));
            3: v = a - longint'($urandom_range(3, 1));
            4: v = $urandom_range(1, 0) ? longint'(TIME_MIN) : longint'(TIME_MAX);
            default: return $urandom;
        endcase
        return to_time(v);
    endfunction

    // one request transaction, with an optional idle burst ahead of it
    task automatic push_request(logic req, logic [IDX_W-1:0] idx,
                                logic signed [TIME_W-1:0] et,
                                logic signed [TIME_W-1:0] qt);
        if (pausing && $urandom_range(3, 0) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(13, 1)) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_req_type    <= req;
        i_entry_index <= idx;
        i_entry_time  <= et;
        i_query_time  <= qt;
        do @(posedge i_clk); while (busy);
        sb.take_request(req, idx, et, qt);
    endtask

    // wait for every outstanding query, then let trailing writes finish
    task automatic drain();
        start <= 1'b0;
        while (sb.pending_index.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // entry_count write while the block is idle
    task automatic retune(logic [CNT_W-1:0] cnt);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cnt;
        @(posedge i_clk);
        i_cfg_we       <= 1'b0;
        sb.stamp_count  = cnt;
        configs++;
    endtask

    // fill entries 0..m-1, ascending unless shuffled; step size sets duplicate density
    task automatic load_table(int m, bit shuffled);
        longint g;
        longint span;
        longint v;
        case ($urandom_range(3, 0))
            0: g = 3;
            1: g = 262144;
            2: g = (m > 1) ? 64'sd4294967295 / (m - 1) : 64'sd0;
            default: g = $urandom_range(1000, 1);
        endcase
        span = (m > 1) ? g * (m - 1) : 64'sd0;
        v    = longint'(TIME_MIN) + (longint'($urandom) % (64'sd4294967296 - span));
        if ($urandom_range(7, 0) == 0) v = longint'(TIME_MIN);
        for (int i = 0; i < m; i++) begin
            if (i > 0) v = v + longint'($urandom_range(32'(g), 0));
            push_request(REQ_WRITE, IDX_W'(i), shuffled ? $urandom : TIME_W'(v), $urandom);
        end
    endtask

    // ascending stamps on the entries that the lowest and highest searches of a
    // full-depth table read: 2^k-1 on the way down, 1023-2^k and 1023 on the way up
    task automatic load_spine();
        longint g;
        int     idx;
        g = ($urandom_range(1, 0) != 0) ? 64'sd4198404 : longint'($urandom_range(1000, 0));
        for (int k = 0; k < 19; k++) begin
            idx = (k < 10) ? (1 << (k + 1)) - 1 : TABLE_DEPTH - 1 - (1 << (k - 10));
            push_request(REQ_WRITE, IDX_W'(idx),
                         TIME_W'(longint'(TIME_MIN) + longint'(idx) * g), $urandom);
        end
        spine_ready = 1'b1;
    endtask

    // queries with a sprinkling of stray table writes; searches stay on written entries
    task automatic run_queries(int m, int k);
        logic signed [TIME_W-1:0] q;
        repeat (k) begin
            if ($urandom_range(15, 0) == 0) begin
                push_request(REQ_WRITE, IDX_W'($urandom), $urandom, $urandom);
            end else begin
                q = pick_query(m);
                for (int t = 0; t < 8 && !sb.walk_loaded(q); t++) q = pick_query(m);
                if (!sb.walk_loaded(q)) q = TIME_MIN;
                push_request(REQ_QUERY, IDX_W'($urandom), $urandom, q);
            end
        end
    endtask

    task automatic run_phase(logic [CNT_W-1:0] cnt, bit fresh, bit shuffled, int k);
        int m;
        m = (cnt > TABLE_DEPTH) ? TABLE_DEPTH : int'(cnt);
        retune(cnt);
        if (m > 40) begin
            if (fresh || !spine_ready) load_spine();
        end else if (fresh || !sb.filled(m)) begin
            load_table(m, shuffled);
        end
        run_queries(m, k);
    endtask

    // stimulus
    initial begin
        int p;
        int r;
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty and single-entry tables, then a five-entry table of extremes
        retune(CNT_W'(0));
        push_request(REQ_WRITE, IDX_W'(0), TIME_MIN, $urandom);
        push_request(REQ_WRITE, IDX_W'(1), -32'sd65536, $urandom);
        push_request(REQ_WRITE, IDX_W'(2), 32'sd0, $urandom);
        push_request(REQ_WRITE, IDX_W'(3), 32'sh0002_0000, $urandom);
        push_request(REQ_WRITE, IDX_W'(4), TIME_MAX, $urandom);
        push_request(REQ_WRITE, IDX_W'(TABLE_DEPTH - 1), 32'sh1234_5678, $urandom);
        push_request(REQ_QUERY, '0, '0, TIME_MIN);
        push_request(REQ_QUERY, '1, '1, TIME_MAX);
        retune(CNT_W'(1));
        push_request(REQ_QUERY, IDX_W'($urandom), $urandom, 32'sh0001_0000);
        retune(CNT_W'(5));
        foreach (corner_times[i])
            push_request(REQ_QUERY, IDX_W'($urandom), $urandom, corner_times[i]);

        // random phases: small sorted and some unsorted tables, a sparse full-depth table, saturated counts
        p = 0;
        while (sb.queries < QUERY_TARGET) begin
            pausing = (sb.queries < QUIET_FROM) && ($urandom_range(3, 0) != 0);
            r       = $urandom_range(19, 0);
            case (p)
                3: run_phase(CNT_W'(TABLE_DEPTH), 1'b1, 1'b0, 40);
                4: run_phase(CNT_W'(2047), 1'b0, 1'b0, 30);
                5: run_phase(CNT_W'(TABLE_DEPTH - 1), 1'b0, 1'b0, 30);
                default: begin
                    if (r < 2)
                        run_phase(CNT_W'($urandom_range(1, 0)), 1'b0, 1'b0, 6);
                    else if (r < 4 && spine_ready)
                        run_phase(CNT_W'($urandom_range(2047, 1023)), 1'b0, 1'b0, 20);
                    else
                        run_phase(CNT_W'($urandom_range(40, 2)), 1'b1, r == 19,
                                  $urandom_range(30, 8));
                end
            endcase
            p++;
        end

        drain();
        $display("tb: %0d queries checked after %0d table writes, %0d entry_count settings",
                 sb.queries, sb.writes, configs);
        $display("tb: counts 0 to 2047, sorted tables with ties, some unsorted, up to %0d entries",
                 TABLE_DEPTH);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
